/* rtl/mt_pkg.sv */
`timescale 1ns / 1ps

package mt_pkg;

    localparam int STATE_WORDS = 624;
    localparam int ADDR_W      = $clog2(STATE_WORDS);
    localparam int TAP_OFFSET  = 397;

    localparam logic [31:0] SEED_MULT  = 32'd1812433253;
    localparam int          SEED_SHIFT = 30;
    localparam logic [31:0] UPPER_MASK = 32'h8000_0000;
    localparam logic [31:0] LOWER_MASK = 32'h7fff_ffff;
    localparam logic [31:0] TWIST_XOR  = 32'h9908_b0df;
    localparam int          TEMPER_U   = 11;
    localparam int          TEMPER_S   = 7;
    localparam int          TEMPER_T   = 15;
    localparam int          TEMPER_L   = 18;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);

    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic
    {
        OP_RESEED = 1'b0,
        OP_DRAW   = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEED,
        ST_COMMIT
    } state_t;

    typedef struct packed
    {
        logic load_seed;
        logic seed_step;
        logic read_issue;
        logic commit;
    } cmd_t;

    typedef struct packed
    {
        logic seed_last;
        logic out_free;
    } status_t;

    // a + b modulo the table depth, both operands below the depth
    function automatic addr_t wrap_add(input addr_t a, input addr_t b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (ADDR_W+1)'(STATE_WORDS))
        begin
            sum = sum - (ADDR_W+1)'(STATE_WORDS);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [31:0] seed_next(input logic [31:0] w, input addr_t k);
        logic [31:0] mix;
        mix = w ^ (w >> SEED_SHIFT);
        return 32'(SEED_MULT * mix) + {{(32-ADDR_W){1'b0}}, k};
    endfunction

    function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
                                          input logic [31:0] tap);
        logic [31:0] y;
        logic [31:0] w;
        y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
        w = tap ^ (y >> 1);
        if (y[0])
        begin
            w = w ^ TWIST_XOR;
        end
        return w;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> TEMPER_U);
        y = y ^ ((y << TEMPER_S) & TEMPER_B);
        y = y ^ ((y << TEMPER_T) & TEMPER_C);
        y = y ^ (y >> TEMPER_L);
        return y;
    endfunction

endpackage

/* rtl/mt_if.sv */
`timescale 1ns / 1ps

interface mt_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

interface mt_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

/* rtl/mt_ctrl.sv */
`timescale 1ns / 1ps

module mt_ctrl
    import mt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  logic    req_opcode,
    output logic    req_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_opcode == OP_DRAW)
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_COMMIT;
                    end
                    else
                    begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_SEED;
                    end
                end
            end
            ST_SEED:
            begin
                cmd.seed_step = 1'b1;
                if (status.seed_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMMIT:
            begin
                // hold the read data until the output slot frees up
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/mt_datapath.sv */
`timescale 1ns / 1ps

module mt_datapath
    import mt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] seed_value,
    input  cmd_t        cmd,
    output status_t     status,
    mt_rsp_if.source    rsp
);

    logic [31:0] table_mem [STATE_WORDS];

    addr_t       pos_reg;
    addr_t       pos_next;
    addr_t       seed_idx_reg;
    logic [31:0] seed_word_reg;
    logic [31:0] cur_word_reg;
    logic [31:0] rd_next_reg;
    logic [31:0] rd_tap_reg;
    logic [31:0] word_reg;
    logic        out_valid_reg;

    addr_t       wr_addr;
    logic [31:0] wr_data;
    logic        wr_en;
    logic [31:0] new_word;
    addr_t       tap_addr;

    assign pos_next = wrap_add(pos_reg, addr_t'(1));
    assign tap_addr = wrap_add(pos_reg, addr_t'(TAP_OFFSET));
    assign new_word = twist(cur_word_reg, rd_next_reg, rd_tap_reg);

    assign wr_en   = cmd.seed_step | cmd.commit;
    assign wr_addr = cmd.seed_step ? seed_idx_reg : pos_reg;
    assign wr_data = cmd.seed_step ? seed_word_reg : new_word;

    assign status.seed_last = (seed_idx_reg == LAST_ADDR);
    assign status.out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.random_word = word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (cmd.read_issue)
        begin
            rd_next_reg <= table_mem[pos_next];
            rd_tap_reg  <= table_mem[tap_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            seed_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_seed)
            begin
                pos_reg      <= '0;
                seed_idx_reg <= '0;
            end
            else if (cmd.seed_step)
            begin
                seed_idx_reg <= seed_idx_reg + addr_t'(1);
            end
            if (cmd.commit)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
        begin
            seed_word_reg <= seed_value;
            cur_word_reg  <= seed_value;
        end
        else if (cmd.seed_step)
        begin
            seed_word_reg <= seed_next(seed_word_reg, seed_idx_reg + addr_t'(1));
        end
        if (cmd.commit)
        begin
            // next position's word is the one just read
            cur_word_reg <= rd_next_reg;
            word_reg     <= temper(new_word);
        end
    end

endmodule

/* rtl/mersenne_twister_prng_top.sv */
`timescale 1ns / 1ps
// mt19937 random word generator
// req channel: opcode 0 reseeds the 624-word table from seed_value,
//   opcode 1 draws one tempered 32-bit word; a transaction completes
//   when valid and ready are both high
// rsp channel: one random_word transaction per draw, none per reseed
// a draw: the accept cycle reads the next and tap words from the
//   two-read-port table; the commit state then twists, writes back and
//   loads the output register when free; only then is a new request taken
// a reseed writes all 624 table words after its accept, one write per cycle
//   through the seed multiplier; no transaction is accepted meanwhile
// reset clears the read position and the output valid; the table holds
//   garbage until the first reseed, so draws must follow a reseed
// a stalled receiver holds the current word; one more draw can be accepted
//   and waits in its commit cycle until the output register frees up

module mersenne_twister_prng_top
    import mt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    mt_req_if.sink   req,
    mt_rsp_if.source rsp
);

    cmd_t    cmd;
    status_t status;

    mt_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .status     (status),
        .cmd        (cmd)
    );

    mt_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_value (req.seed_value),
        .cmd        (cmd),
        .status     (status),
        .rsp        (rsp)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import mt_pkg::*;

    localparam int N_RANDOM   = 1500;
    localparam int QUIET_FROM = 1300;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 200;
    localparam int WATCHDOG   = 5000;
    localparam int DRAIN      = 20;

    class mt_scoreboard;
        logic [31:0] words [STATE_WORDS];
        int unsigned pos;
        logic [31:0] expected_words [$];
        int errors;

        function new();
            foreach (words[k])
            begin
                words[k] = '0;
            end
            pos = 0;
            errors = 0;
        endfunction

        task report(input string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void refill(input logic [31:0] seed);
            logic [31:0] prev;
            words[0] = seed;
            for (int k = 1; k < STATE_WORDS; k++)
            begin
                prev = words[k-1];
                words[k] = SEED_MULT * (prev ^ (prev >> SEED_SHIFT)) + 32'(k);
            end
            pos = 0;
        endfunction

        function logic [31:0] next_word();
            logic [31:0] y;
            logic [31:0] w;
            y = (words[pos] & UPPER_MASK) | (words[(pos + 1) % STATE_WORDS] & LOWER_MASK);
            w = words[(pos + TAP_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0])
            begin
                w = w ^ TWIST_XOR;
            end
            words[pos] = w;
            pos = (pos + 1) % STATE_WORDS;
            w = w ^ (w >> TEMPER_U);
            w = w ^ ((w << TEMPER_S) & TEMPER_B);
            w = w ^ ((w << TEMPER_T) & TEMPER_C);
            w = w ^ (w >> TEMPER_L);
            return w;
        endfunction

        function void note_request(input opcode_t op, input logic [31:0] seed);
            if (op == OP_RESEED)
            begin
                refill(seed);
            end
            else
            begin
                expected_words.push_back(next_word());
            end
        endfunction

        task check_word(input logic [31:0] got);
            logic [31:0] want;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected random_word %08h", got));
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    report($sformatf("random_word %08h, expected %08h", got, want));
                end
            end
        endtask

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic idle_on;
    logic hold_done;
    int   req_count;
    int   quiet_cycles;

    mt_req_if req_ch ();
    mt_rsp_if rsp_ch ();

    mt_scoreboard sb;

    mersenne_twister_prng_top u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    // transaction monitor, response checked before the request of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_word(rsp_ch.random_word);
            end
            if (req_ch.valid && req_ch.ready)
            begin
                sb.note_request(opcode_t'(req_ch.opcode), req_ch.seed_value);
                req_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)))
        begin
            quiet_cycles++;
        end
        else
        begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("TEST FAILED");
            $finish;
        end
    end

    task send_item(input opcode_t op, input logic [31:0] seed);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.opcode     = op;
        req_ch.seed_value = seed;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && req_count >= HOLD_AT)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_done = 1'b1;
                rsp_ch.ready = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready = 1'b0;
                gap = $urandom_range(0, 14);
                repeat (gap) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    initial
    begin
        int          draws_since;
        logic [31:0] seed;
        clk               = 1'b0;
        rst_n             = 1'b0;
        idle_on           = 1'b1;
        hold_done         = 1'b0;
        req_count         = 0;
        quiet_cycles      = 0;
        req_ch.valid      = 1'b0;
        req_ch.opcode     = OP_RESEED;
        req_ch.seed_value = '0;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extreme seeds, ignored seed_value on draws, repeated reseed
        send_item(OP_RESEED, 32'h0000_0000);
        send_item(OP_DRAW, 32'h0000_0000);
        send_item(OP_DRAW, 32'hffff_ffff);
        send_item(OP_DRAW, 32'h0000_0000);
        send_item(OP_RESEED, 32'hffff_ffff);
        send_item(OP_DRAW, 32'hffff_ffff);
        send_item(OP_DRAW, 32'h0000_0000);
        send_item(OP_DRAW, 32'ha5a5_5a5a);
        send_item(OP_RESEED, 32'd5489);
        repeat (4) send_item(OP_DRAW, $urandom);
        send_item(OP_RESEED, 32'h0000_0001);
        send_item(OP_RESEED, 32'h8000_0000);
        send_item(OP_DRAW, 32'h0000_0001);
        send_item(OP_DRAW, 32'h8000_0000);
        send_item(OP_RESEED, 32'h7fff_ffff);
        send_item(OP_DRAW, 32'h7fff_ffff);
        send_item(OP_RESEED, $urandom);
        send_item(OP_DRAW, $urandom);

        // random: long draw runs so the position wraps, occasional reseeds
        draws_since = 0;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i >= QUIET_FROM)
            begin
                idle_on = 1'b0;
            end
            if ((draws_since > 650 && $urandom_range(0, 49) == 0) ||
                $urandom_range(0, 599) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       seed = 32'h0000_0000;
                    1:       seed = 32'hffff_ffff;
                    default: seed = $urandom;
                endcase
                send_item(OP_RESEED, seed);
                draws_since = 0;
            end
            else
            begin
                send_item(OP_DRAW, $urandom);
                draws_since++;
            end
        end
        req_ch.valid = 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
